### rtl/latlon_local_projection_macros.svh
// ----------------------------------------------------------------------------
// latlon_local_projection_macros
// Assertion macros shared by the projection RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LATLON_LOCAL_PROJECTION_MACROS_SVH
`define LATLON_LOCAL_PROJECTION_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define LLP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("llp assertion failed");
// clocked check that also holds during reset
`define LLP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("llp assertion failed");
`else
`define LLP_ASSERT(label, prop)
`define LLP_ASSERT_ALWAYS(label, prop)
`endif

`endif

### rtl/llp_pkg.sv
// ----------------------------------------------------------------------------
// llp_pkg
// Shared widths, constants and CORDIC arctangent table for the projection.
// ----------------------------------------------------------------------------
`default_nettype none

package llp_pkg;

    // cordic datapath width (signed)
    localparam int CW  = 34;
    // square root datapath width (unsigned)
    localparam int SQW = 63;
    // pipeline depth of one pixel scaling unit
    localparam int PIX_LAT = 5;
    // steps of the square root chain (one result bit each)
    localparam int SQRT_STEPS = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_LAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_LON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd4;

    localparam logic [22:0] RADIUS_RESET = 23'd6371000;

    // angle constants, radians in Q30
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
    localparam logic [31:0] PI_Q30         = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
    localparam logic [30:0] ONE_Q30        = 31'd1073741824;
    localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;

    localparam logic [31:0] OUT_MAX = 32'hFFFF_FFFF;

    // atan(2^-i) in Q30
    function automatic logic [CW-1:0] atan_q30(input int unsigned idx);
        logic [CW-1:0] a;
        case (idx)
            0:  a = 34'h3243F6A8;
            1:  a = 34'h1DAC6705;
            2:  a = 34'h0FADBAFC;
            3:  a = 34'h07F56EA6;
            4:  a = 34'h03FEAB76;
            5:  a = 34'h01FFD55B;
            6:  a = 34'h00FFFAAA;
            7:  a = 34'h007FFF55;
            8:  a = 34'h003FFFEA;
            9:  a = 34'h001FFFFD;
            10: a = 34'h000FFFFF;
            11: a = 34'h0007FFFF;
            12: a = 34'h0003FFFF;
            13: a = 34'h0001FFFF;
            14: a = 34'h0000FFFF;
            15: a = 34'h00007FFF;
            16: a = 34'h00003FFF;
            17: a = 34'h00001FFF;
            18: a = 34'h00000FFF;
            19: a = 34'h000007FF;
            20: a = 34'h000003FF;
            21: a = 34'h000001FF;
            22: a = 34'h000000FF;
            23: a = 34'h0000007F;
            24: a = 34'h0000003F;
            25: a = 34'h0000001F;
            26: a = 34'h0000000F;
            27: a = 34'h00000008;
            28: a = 34'h00000004;
            29: a = 34'h00000002;
            30: a = 34'h00000001;
            default: a = '0;
        endcase
        return a;
    endfunction

    // clamp a cordic value into [0, 1.0] Q30
    function automatic logic [30:0] clamp_one(input logic signed [CW-1:0] v);
        logic [30:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({3'b000, ONE_Q30}))
            r = ONE_Q30;
        else
            r = v[30:0];
        return r;
    endfunction

    // clamp a cordic angle into [0, pi/2] Q30
    function automatic logic [30:0] clamp_half_pi(input logic signed [CW-1:0] v);
        logic [30:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({3'b000, HALF_PI_Q30}))
            r = HALF_PI_Q30;
        else
            r = v[30:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/latlon_local_projection.sv
// ----------------------------------------------------------------------------
// latlon_local_projection
// Lat/lon point to local map pixels from a reference corner via haversine.
// ----------------------------------------------------------------------------
// One point is accepted every clock cycle while the result side keeps up;
// each point comes out in order. The pipe is a chain of cells: a sin/cos
// rotation CORDIC of CORDIC_STAGES cells (capped at 32), a 32-cell square
// root, an arcsine vectoring CORDIC of CORDIC_STAGES cells (also capped at 32)
// and the front and back scaling stages. The whole pipe advances together and
// holds while a result beat waits under stall. The user must write registers
// only while the pipe is empty; the block itself does not enforce this.
`default_nettype none
`include "latlon_local_projection_macros.svh"

module latlon_local_projection
    import llp_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // point channel
    input  wire logic                 point_valid,
    output logic                      point_stall,
    input  wire logic signed [29:0]   point_lat,
    input  wire logic signed [30:0]   point_lon,
    // result channel
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [31:0]               x_pos,
    output logic [31:0]               y_pos,
    output logic                      saturated,
    // register write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int N   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT = 2 * N + 43 + PIX_LAT;
    localparam int XD  = 2 * N + 38;
    localparam int TD  = SQRT_STEPS + 2;

    // configuration registers
    logic signed [29:0] ref_lat_reg;
    logic signed [30:0] ref_lon_reg;
    logic [31:0]        x_scale_reg;
    logic [31:0]        y_scale_reg;
    logic [22:0]        radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lat_reg <= '0;
            ref_lon_reg <= '0;
            x_scale_reg <= '0;
            y_scale_reg <= '0;
            radius_reg  <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REF_LAT: ref_lat_reg <= cfg_data[29:0];
                REG_REF_LON: ref_lon_reg <= cfg_data[30:0];
                REG_X_SCALE: x_scale_reg <= cfg_data;
                REG_Y_SCALE: y_scale_reg <= cfg_data;
                REG_RADIUS:  radius_reg  <= cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // pipe control: everything moves unless the output beat is held
    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en           = !(vld_reg[LAT-1] && result_stall);
    assign point_stall  = vld_reg[LAT-1] && result_stall;
    assign result_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], point_valid};
    end

    // front end, three lanes: lat difference, lon difference, lat sum
    logic [32:0] diff [3];
    logic [31:0] mag_reg  [3];
    logic [56:0] prod_reg [3];
    logic [56:0] prod_rnd [3];
    logic [32:0] ang_reg  [3];
    logic [31:0] mod_reg  [3];
    logic [30:0] h_reg    [3];

    always_comb
    begin
        diff[0] = {{3{point_lat[29]}}, point_lat} - {{3{ref_lat_reg[29]}}, ref_lat_reg};
        diff[1] = {{2{point_lon[30]}}, point_lon} - {{2{ref_lon_reg[30]}}, ref_lon_reg};
        diff[2] = {{3{point_lat[29]}}, point_lat} + {{3{ref_lat_reg[29]}}, ref_lat_reg};
        for (int i = 0; i < 3; i++)
            prod_rnd[i] = prod_reg[i] + 57'd4194304;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // magnitude in degrees * 2^23 of the half angle
                mag_reg[i]  <= diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
                // to radians Q30
                prod_reg[i] <= 57'(mag_reg[i]) * 57'(DEG_TO_RAD_Q30);
                ang_reg[i]  <= prod_rnd[i][55:23];
                // subtract pi once if at or above pi, then fold into [0, pi/2]
                mod_reg[i]  <= (ang_reg[i] >= {1'b0, PI_Q30}) ?
                               32'(ang_reg[i] - {1'b0, PI_Q30}) : ang_reg[i][31:0];
                h_reg[i]    <= (mod_reg[i] > {1'b0, HALF_PI_Q30}) ?
                               31'(PI_Q30 - mod_reg[i]) : mod_reg[i][30:0];
            end
        end
    end

    // sin of half lon difference and cos of mean lat
    logic signed [CW-1:0] sx [N+1];
    logic signed [CW-1:0] sy [N+1];
    logic signed [CW-1:0] sz [N+1];
    logic signed [CW-1:0] cx [N+1];
    logic signed [CW-1:0] cy [N+1];
    logic signed [CW-1:0] cz [N+1];

    assign sx[0] = CORDIC_START;
    assign sy[0] = '0;
    assign sz[0] = $signed({3'b000, h_reg[1]});
    assign cx[0] = CORDIC_START;
    assign cy[0] = '0;
    assign cz[0] = $signed({3'b000, h_reg[2]});

    for (genvar j = 0; j < N; j++)
    begin : g_rot
        llp_cordic_cell #(.STAGE(j), .VECTOR(1'b0)) u_sin (
            .clk   (clk),
            .en    (en),
            .x_in  (sx[j]),
            .y_in  (sy[j]),
            .z_in  (sz[j]),
            .x_out (sx[j+1]),
            .y_out (sy[j+1]),
            .z_out (sz[j+1])
        );
        llp_cordic_cell #(.STAGE(j), .VECTOR(1'b0)) u_cos (
            .clk   (clk),
            .en    (en),
            .x_in  (cx[j]),
            .y_in  (cy[j]),
            .z_in  (cz[j]),
            .x_out (cx[j+1]),
            .y_out (cy[j+1]),
            .z_out (cz[j+1])
        );
    end

    // t = sin * cos, then 1 - t^2 for the arcsine start vector
    logic [30:0]  s_reg;
    logic [30:0]  c_reg;
    logic [61:0]  sc_reg;
    logic [61:0]  sc_rnd;
    logic [30:0]  t_reg;
    logic [61:0]  tsq_reg;
    logic [SQW-1:0] v_reg;
    logic [30:0]  t_dly [TD];

    assign sc_rnd = sc_reg + 62'd536870912;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= clamp_one(sy[N]);
            c_reg   <= clamp_one(cx[N]);
            sc_reg  <= 62'(s_reg) * 62'(c_reg);
            t_reg   <= (sc_rnd[61:30] > {1'b0, ONE_Q30}) ? ONE_Q30 : sc_rnd[60:30];
            tsq_reg <= 62'(t_reg) * 62'(t_reg);
            v_reg   <= (SQW'(1) << 60) - SQW'(tsq_reg);
            t_dly[0] <= t_reg;
            for (int k = 1; k < TD; k++)
                t_dly[k] <= t_dly[k-1];
        end
    end

    // integer square root chain
    logic [SQW-1:0] qv [SQRT_STEPS+1];
    logic [SQW-1:0] qr [SQRT_STEPS+1];

    assign qv[0] = v_reg;
    assign qr[0] = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        llp_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_sq (
            .clk     (clk),
            .en      (en),
            .v_in    (qv[j]),
            .res_in  (qr[j]),
            .v_out   (qv[j+1]),
            .res_out (qr[j+1])
        );
    end

    // arcsine by vectoring on (sqrt(1 - t^2), t)
    logic signed [CW-1:0] vx [N+1];
    logic signed [CW-1:0] vy [N+1];
    logic signed [CW-1:0] vz [N+1];

    assign vx[0] = $signed({3'b000, qr[SQRT_STEPS][30:0]});
    assign vy[0] = $signed({3'b000, t_dly[TD-1]});
    assign vz[0] = '0;

    for (genvar j = 0; j < N; j++)
    begin : g_vec
        llp_cordic_cell #(.STAGE(j), .VECTOR(1'b1)) u_asin (
            .clk   (clk),
            .en    (en),
            .x_in  (vx[j]),
            .y_in  (vy[j]),
            .z_in  (vz[j]),
            .x_out (vx[j+1]),
            .y_out (vy[j+1]),
            .z_out (vz[j+1])
        );
    end

    // central angles: y from arcsine, x delayed to line up with it
    logic [31:0] cy_reg;
    logic [31:0] cx_dly [XD];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cy_reg    <= {clamp_half_pi(vz[N]), 1'b0};
            cx_dly[0] <= {h_reg[0], 1'b0};
            for (int k = 1; k < XD; k++)
                cx_dly[k] <= cx_dly[k-1];
        end
    end

    // meters and pixels for each axis
    logic sat_x;
    logic sat_y;

    llp_pix u_pix_x (
        .clk    (clk),
        .en     (en),
        .ang    (cx_dly[XD-1]),
        .radius (radius_reg),
        .scale  (x_scale_reg),
        .pos    (x_pos),
        .sat    (sat_x)
    );

    llp_pix u_pix_y (
        .clk    (clk),
        .en     (en),
        .ang    (cy_reg),
        .radius (radius_reg),
        .scale  (y_scale_reg),
        .pos    (y_pos),
        .sat    (sat_y)
    );

    assign saturated = sat_x | sat_y;

    // checks
    `LLP_ASSERT(a_sat_clipped, result_valid && saturated |-> (x_pos == OUT_MAX || y_pos == OUT_MAX))
    `LLP_ASSERT(a_t_range, vld_reg[N+7] |-> t_reg <= ONE_Q30)
    `LLP_ASSERT(a_cy_range, vld_reg[2*N+42] |-> cy_reg <= PI_Q30)
    `LLP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !result_valid)

endmodule

`default_nettype wire

### rtl/llp_cordic_cell.sv
// ----------------------------------------------------------------------------
// llp_cordic_cell
// One CORDIC micro-rotation, registered; rotation or vectoring mode.
// ----------------------------------------------------------------------------
`default_nettype none

module llp_cordic_cell
    import llp_pkg::*;
#(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0
)
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [CW-1:0] x_in,
    input  wire logic signed [CW-1:0] y_in,
    input  wire logic signed [CW-1:0] z_in,
    output logic signed [CW-1:0]      x_out,
    output logic signed [CW-1:0]      y_out,
    output logic signed [CW-1:0]      z_out
);

    localparam logic signed [CW-1:0] ATAN = atan_q30(STAGE);

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic                 up;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] z_next;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;

    // direction: rotate toward z = 0, or toward y = 0 when vectoring
    always_comb
    begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        up = VECTOR ? y_in[CW-1] : !z_in[CW-1];
        if (up)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

### rtl/llp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// llp_sqrt_cell
// One restoring step of a digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module llp_sqrt_cell
    import llp_pkg::*;
#(
    parameter int K = 31
)
(
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [SQW-1:0] v_in,
    input  wire logic [SQW-1:0] res_in,
    output logic [SQW-1:0]      v_out,
    output logic [SQW-1:0]      res_out
);

    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

    logic [SQW-1:0] trial;
    logic [SQW-1:0] v_next;
    logic [SQW-1:0] res_next;
    logic [SQW-1:0] v_reg;
    logic [SQW-1:0] res_reg;

    // try to take the next result bit
    always_comb
    begin
        trial = res_in + BIT;
        if (v_in >= trial)
        begin
            v_next   = v_in - trial;
            res_next = (res_in >> 1) + BIT;
        end
        else
        begin
            v_next   = v_in;
            res_next = res_in >> 1;
        end
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
        end
    end

    assign v_out   = v_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

### rtl/llp_pix.sv
// ----------------------------------------------------------------------------
// llp_pix
// Central angle to meters to scaled pixels, saturated; five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module llp_pix
    import llp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] ang,
    input  wire logic [22:0] radius,
    input  wire logic [31:0] scale,
    output logic [31:0]      pos,
    output logic             sat
);

    logic [54:0] rc_reg;
    logic [55:0] rc_round;
    logic [40:0] d_reg;
    logic [56:0] ph_reg;
    logic [56:0] pl_reg;
    logic [73:0] sum_next;
    logic [73:0] sum_reg;
    logic [53:0] r;
    logic [31:0] pos_reg;
    logic        sat_reg;

    // radius times angle, then round to meters Q16
    always_comb
    begin
        rc_round = {1'b0, rc_reg} + 56'd8192;
        sum_next = ({17'd0, ph_reg} << 16) + {17'd0, pl_reg} + 74'd524288;
        r        = sum_reg[73:20];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rc_reg  <= 55'(radius) * 55'(ang);
            d_reg   <= rc_round[54:14];
            // split scale into high and low halves
            ph_reg  <= 57'(d_reg) * 57'(scale[31:16]);
            pl_reg  <= 57'(d_reg) * 57'(scale[15:0]);
            sum_reg <= sum_next;
            // saturate to the output range
            if (|r[53:32])
            begin
                pos_reg <= OUT_MAX;
                sat_reg <= 1'b1;
            end
            else
            begin
                pos_reg <= r[31:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign pos = pos_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks latlon_local_projection beat by beat against a fixed-point
// haversine predictor, over directed corners and random points, with random
// gaps on both channels and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import llp_pkg::*;

    localparam int STAGES = 24;
    localparam int LATENCY = 2 * STAGES + 48;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        sat;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic point_valid = 1'b0;
    logic point_stall;
    logic signed [29:0] point_lat = '0;
    logic signed [30:0] point_lon = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [31:0] x_pos, y_pos;
    logic saturated;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predictor copy of the registers
    logic [29:0] m_ref_lat = '0;
    logic [30:0] m_ref_lon = '0;
    logic [31:0] m_x_scale = '0, m_y_scale = '0;
    logic [22:0] m_radius = RADIUS_RESET;

    pixel_t pending_pixels[$];
    int errors = 0;
    bit stalls_on = 1'b1;

    latlon_local_projection #(.CORDIC_STAGES(STAGES)) dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint atan_at(int i);
        longint tab[32] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
            64'h00000001, 64'h00000000};
        return tab[i];
    endfunction

    function automatic longint clip(longint v, longint hi);
        if (v < 0)
            return 0;
        return (v > hi) ? hi : v;
    endfunction

    // magnitude in degrees*2^23 to folded radians Q30
    function automatic longint fold_rad(longint d);
        longint unsigned m, a;
        m = (d < 0) ? -d : d;
        a = (m * 64'd18740330 + (64'd1 << 22)) >> 23;
        a = a % 64'd3373259426;
        if (a > 64'd1686629713)
            a = 64'd3373259426 - a;
        return a;
    endfunction

    // rotation cordic, returns {sin, cos} clamped
    function automatic void rotate(longint ang, output longint s, output longint c);
        longint x, y, z, xs, ys;
        x = 652032874;
        y = 0;
        z = ang;
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_at(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_at(i);
            end
        end
        s = clip(y, 64'd1 << 30);
        c = clip(x, 64'd1 << 30);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint arcsine(longint t);
        longint x, y, z, xs, ys;
        x = int_sqrt((64'd1 << 60) - t * t);
        y = t;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atan_at(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_at(i);
            end
        end
        return clip(z, 64'd1686629713);
    endfunction

    function automatic longint unsigned scale_pixels(longint unsigned ang,
            logic [31:0] scale, inout bit sat);
        longint unsigned d, ph, t, r;
        d = (longint'(m_radius) * ang + (64'd1 << 13)) >> 14;
        ph = d * scale[31:16];
        t = d * scale[15:0] + ((ph & 64'hF) << 16) + (64'd1 << 19);
        r = (ph >> 4) + (t >> 20);
        if (r > 64'hFFFF_FFFF)
        begin
            sat = 1'b1;
            return 64'hFFFF_FFFF;
        end
        return r;
    endfunction

    function automatic pixel_t project_point(logic signed [29:0] plat,
            logic signed [30:0] plon);
        longint rlat, rlon, s, c, dummy, t, cx, cy;
        bit sat;
        pixel_t p;
        sat = 1'b0;
        rlat = $signed(m_ref_lat);
        rlon = $signed(m_ref_lon);
        cx = 2 * fold_rad(longint'(plat) - rlat);
        rotate(fold_rad(longint'(plon) - rlon), s, dummy);
        rotate(fold_rad(longint'(plat) + rlat), dummy, c);
        t = (s * c + (64'd1 << 29)) >>> 30;
        if (t > (64'd1 << 30))
            t = 64'd1 << 30;
        cy = 2 * arcsine(t);
        p.x = 32'(scale_pixels(cx, m_x_scale, sat));
        p.y = 32'(scale_pixels(cy, m_y_scale, sat));
        p.sat = sat;
        return p;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_REF_LAT: m_ref_lat = value[29:0];
            REG_REF_LON: m_ref_lon = value[30:0];
            REG_X_SCALE: m_x_scale = value;
            REG_Y_SCALE: m_y_scale = value;
            REG_RADIUS:  m_radius = value[22:0];
            default: ;
        endcase
    endtask

    task automatic send_point(logic signed [29:0] plat, logic signed [30:0] plon,
            bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_valid <= 1'b1;
        point_lat <= plat;
        point_lon <= plon;
        pending_pixels.push_back(project_point(plat, plon));
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
    endtask

    task automatic end_burst;
        point_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic signed [29:0] rand_lat(bit any);
        if (any)
            return 30'($urandom());
        return $signed(30'($urandom_range(0, 754974720))) - 30'sd377487360;
    endfunction

    function automatic logic signed [30:0] rand_lon(bit any);
        if (any)
            return 31'($urandom());
        return $signed(31'($urandom_range(0, 1509949440))) - 31'sd754974720;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (x_pos !== want.x)
                begin
                    $error("x_pos expected %h got %h", want.x, x_pos);
                    errors++;
                end
                if (y_pos !== want.y)
                begin
                    $error("y_pos expected %h got %h", want.y, y_pos);
                    errors++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated expected %b got %b", want.sat, saturated);
                    errors++;
                end
            end
        end
    end

    // random receiver wait before each beat, when stalls are on
    initial
    begin
        int n;
        forever
        begin
            n = stalls_on ? $urandom_range(0, 16) : 0;
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    task automatic test_directed;
        write_reg(REG_X_SCALE, 32'h0001_0000);
        write_reg(REG_Y_SCALE, 32'h0001_0000);
        send_point(30'sd0, 31'sd0, 1'b0);
        send_point(30'sd377487360, 31'sd754974720, 1'b0);
        send_point(-30'sd377487360, -31'sd754974720, 1'b0);
        send_point(30'sd188743680, 31'sd377487360, 1'b0);
        send_point(30'h1FFF_FFFF, 31'h3FFF_FFFF, 1'b0);
        send_point(30'h2000_0000, 31'h4000_0000, 1'b0);
        send_point(30'h3FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_point(30'sd1, -31'sd1, 1'b0);
        end_burst();
        drain();
        // saturating scales and odd radius
        write_reg(REG_X_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_Y_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_RADIUS, 32'hFFFF_FFFF);
        send_point(30'sd377487360, 31'sd754974720, 1'b0);
        send_point(30'sd0, 31'sd0, 1'b0);
        send_point(-30'sd100, 31'sd50, 1'b0);
        end_burst();
        drain();
        // index past the register list is ignored
        write_reg(3'd7, 32'h1234_5678);
    endtask

    task automatic test_random_settings;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_REF_LAT, (phase == 0) ? 32'd377487360 :
                (phase == 1) ? -32'sd377487360 : $urandom());
            write_reg(REG_REF_LON, (phase == 0) ? 32'd754974720 :
                (phase == 1) ? -32'sd754974720 : $urandom());
            write_reg(REG_X_SCALE, (phase == 2) ? 32'd0 : $urandom() >> $urandom_range(0, 20));
            write_reg(REG_Y_SCALE, (phase == 3) ? 32'hFFFF_FFFF : $urandom() >> $urandom_range(0, 20));
            write_reg(REG_RADIUS, (phase == 4) ? 32'd6000000 :
                (phase == 5) ? 32'd6500000 : $urandom_range(6000000, 6500000));
            stalls_on = (phase != 3);
            for (int k = 0; k < 215; k++)
                send_point(rand_lat($urandom_range(0, 7) == 0),
                    rand_lon($urandom_range(0, 7) == 0), phase != 4);
            end_burst();
            drain();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_settings();
        if (errors == 0)
            $display("latlon_local_projection test passed");
        else
            $display("latlon_local_projection test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("latlon_local_projection test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/llp_pkg.sv
rtl/llp_cordic_cell.sv
rtl/llp_sqrt_cell.sv
rtl/llp_pix.sv
rtl/latlon_local_projection.sv
tb/testbench.sv
